[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion shorthands. They expect clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds on every clock edge outside reset.
`define PSCT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Expression never true outside reset.
`define PSCT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error(msg);

`endif

[hw/rtl/psct_pkg.sv]
// ----------------------------------------------------------------------------
// psct_pkg
// Types and constants of the parabolic sine / cosine / tangent pipeline.
// ----------------------------------------------------------------------------
package psct_pkg;

  localparam int FRAC_BITS = 16;
  localparam int SIN_LAT   = 10;   // register stages in one sine lane
  localparam int DIV_BITS  = 34;   // quotient bits, one per divider stage
  localparam int LATENCY   = SIN_LAT + DIV_BITS + 2;

  localparam logic [24:0] HALF_TURN   = 25'(180 << FRAC_BITS);
  localparam logic [24:0] FULL_TURN   = 25'(360 << FRAC_BITS);
  localparam logic [32:0] QUARTER     = 33'(90 << FRAC_BITS);
  localparam logic [14:0] WRAP_OFFSET = 15'd8235;       // 183 * 45
  localparam logic [10:0] WRAP_RECIP  = 11'd1457;       // ceil(2^16 / 45)
  localparam logic [49:0] SIN_HALF_DEN = 50'd265420800; // 8100 * 2^16 / 2
  localparam logic [27:0] SIN_RECIP   = 28'd135742176;  // floor(2^38 / 2025)
  localparam logic [39:0] COR_HALF_DEN = 40'd1310720;   // 40 * 2^16 / 2
  localparam logic [16:0] DIV5_RECIP  = 17'd52429;      // ceil(2^18 / 5)
  localparam logic signed [31:0] VAL_MAX = 32'sh7FFFFFFF;
  localparam logic signed [31:0] VAL_MIN = 32'sh80000000;

  typedef struct packed {
    logic [2:0]         op;
    logic signed [31:0] angle_degrees;
  } psct_in_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic               saturated;
  } psct_out_t;

  // Side data that rides along the divider stages
  typedef struct packed {
    logic               tan;
    logic               neg;
    logic               zero;
    logic signed [31:0] fix_val;
  } psct_side_t;

endpackage

[hw/rtl/psct_sine.sv]
// ----------------------------------------------------------------------------
// psct_sine
// Ten-stage parabolic sine of an angle in degrees with optional correction.
// ----------------------------------------------------------------------------
module psct_sine (
  input  logic               clk,
  input  logic signed [32:0] ang,
  input  logic               precise,
  output logic signed [17:0] sin_out
);

  logic [8:0]  pr_r;

  // stage 1: coarse turn index, floor mod 45 of angle >> 19
  logic signed [13:0] ahi;
  logic [14:0] u;
  logic [14:0] u_r;
  logic [18:0] lo_r;
  logic [8:0]  qe_r;
  assign ahi = ang[32:19];
  assign u   = 15'($signed({ahi[13], ahi}) + $signed(psct_pkg::WRAP_OFFSET));

  always_ff @(posedge clk) begin
    u_r  <= u;
    lo_r <= ang[18:0];
    qe_r <= 9'((26'(u) * 26'(psct_pkg::WRAP_RECIP)) >> 16);
    pr_r <= {pr_r[7:0], precise};
  end

  // stage 2: remainder, estimate may be one high
  logic signed [16:0] rem2;
  logic signed [16:0] rem2_c;
  logic [24:0] r_r;
  assign rem2   = $signed({2'b00, u_r}) - $signed({1'b0, {7'd0, qe_r} * 16'd45});
  assign rem2_c = rem2[16] ? rem2 + 17'sd45 : rem2;

  always_ff @(posedge clk) begin
    r_r <= {rem2_c[5:0], lo_r};
  end

  // stage 3: fold into (-180, 180]
  logic signed [24:0] x3;
  logic [23:0] ax3;
  logic signed [24:0] x_r;
  logic [23:0] k_r;
  assign x3  = (r_r > psct_pkg::HALF_TURN) ? $signed(r_r - psct_pkg::FULL_TURN)
                                           : $signed(r_r);
  assign ax3 = x3[24] ? 24'(-x3) : 24'(x3);

  always_ff @(posedge clk) begin
    x_r <= x3;
    k_r <= 24'(psct_pkg::HALF_TURN) - ax3;
  end

  // stage 4: x * (180 - |x|)
  logic signed [49:0] prod_r;
  always_ff @(posedge clk) begin
    prod_r <= x_r * $signed({1'b0, k_r});
  end

  // stage 5: magnitude plus half divisor, drop the power-of-two part
  logic [49:0] mag5;
  logic [27:0] n_r;
  logic        neg_r;
  assign mag5 = prod_r[49] ? 50'(-prod_r) : 50'(prod_r);

  always_ff @(posedge clk) begin
    n_r   <= 28'((mag5 + psct_pkg::SIN_HALF_DEN) >> 18);
    neg_r <= prod_r[49];
  end

  // stage 6: quotient estimate by reciprocal of 2025
  logic [16:0] qd_r;
  logic [27:0] n6_r;
  logic        neg6_r;
  always_ff @(posedge clk) begin
    qd_r   <= 17'((56'(n_r) * 56'(psct_pkg::SIN_RECIP)) >> 38);
    n6_r   <= n_r;
    neg6_r <= neg_r;
  end

  // stage 7: correct estimate that is one low, apply sign
  logic [27:0] rem7;
  logic [16:0] q7;
  logic signed [17:0] s_r;
  assign rem7 = n6_r - ({11'd0, qd_r} * 28'd2025);
  assign q7   = (rem7 >= 28'd2025) ? qd_r + 17'd1 : qd_r;

  always_ff @(posedge clk) begin
    s_r <= neg6_r ? -$signed({1'b0, q7}) : $signed({1'b0, q7});
  end

  // stage 8: s * (|s| - 1)
  logic [17:0] as8;
  logic signed [18:0] dm8;
  logic signed [36:0] p_r;
  logic signed [17:0] s8_r;
  assign as8 = s_r[17] ? 18'(-s_r) : 18'(s_r);
  assign dm8 = $signed({1'b0, as8}) - $signed(19'(1 << psct_pkg::FRAC_BITS));

  always_ff @(posedge clk) begin
    p_r  <= s_r * dm8;
    s8_r <= s_r;
  end

  // stage 9: scale by 9, round toward 40 * 2^16
  logic [39:0] pm9;
  logic [39:0] m9;
  logic [16:0] n2_r;
  logic        negc_r;
  logic signed [17:0] s9_r;
  assign pm9 = p_r[36] ? 40'(-p_r) : 40'(p_r);
  assign m9  = pm9 * 40'd9;

  always_ff @(posedge clk) begin
    n2_r   <= 17'((m9 + psct_pkg::COR_HALF_DEN) >> 19);
    negc_r <= p_r[36];
    s9_r   <= s8_r;
  end

  // stage 10: divide by 5, add correction
  logic [16:0] q10;
  logic signed [17:0] corr;
  logic signed [17:0] out_r;
  assign q10  = 17'((35'(n2_r) * 35'(psct_pkg::DIV5_RECIP)) >> 18);
  assign corr = negc_r ? -$signed({1'b0, q10}) : $signed({1'b0, q10});

  always_ff @(posedge clk) begin
    out_r <= pr_r[8] ? s9_r + corr : s9_r;
  end

  assign sin_out = out_r;

endmodule

[hw/rtl/parabolic_sine_cosine_tangent.sv]
// Path: two 10-stage sine lanes, an operand register, a 34-stage restoring divider
// for tangent and an output register, then the out_valid strobe of an accepted request.
// Throughput: one request per cycle; busy is always low.
// Reset (rst_n low, synchronous) clears all valid bits; no result follows.
// ----------------------------------------------------------------------------
// parabolic_sine_cosine_tangent
// Pipelined parabolic sine, cosine and tangent of a Q16.16 angle in degrees.
// ----------------------------------------------------------------------------
module parabolic_sine_cosine_tangent (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  psct_pkg::psct_in_t   in_data,
  output logic                 out_valid,
  output psct_pkg::psct_out_t  out_data
);

  localparam int SL = psct_pkg::SIN_LAT;
  localparam int DB = psct_pkg::DIV_BITS;

  logic in_fire;
  assign busy    = 1'b0;
  assign in_fire = start & ~busy;

  // two sine lanes: angle and angle + 90
  logic signed [32:0] ang_a;
  logic signed [32:0] ang_b;
  logic signed [17:0] sin_v;
  logic signed [17:0] cos_v;
  assign ang_a = {in_data.angle_degrees[31], in_data.angle_degrees};
  assign ang_b = ang_a + $signed(psct_pkg::QUARTER);

  psct_sine u_sin (
    .clk     (clk),
    .ang     (ang_a),
    .precise (in_data.op[0]),
    .sin_out (sin_v)
  );

  psct_sine u_cos (
    .clk     (clk),
    .ang     (ang_b),
    .precise (in_data.op[0]),
    .sin_out (cos_v)
  );

  logic [SL-1:0] sv_r;
  logic [2:0]    sop_r [0:SL-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sv_r <= '0;
    end else begin
      sv_r <= {sv_r[SL-2:0], in_fire};
    end
  end

  always_ff @(posedge clk) begin
    sop_r[0] <= in_data.op;
    for (int i = 1; i < SL; i++) begin
      sop_r[i] <= sop_r[i-1];
    end
  end

  // prepare divider operands
  logic [2:0]  opp;
  logic [16:0] as_p;
  logic [16:0] cd_p;
  logic [33:0] num_p;
  psct_pkg::psct_side_t side_p;
  assign opp   = sop_r[SL-1];
  assign as_p  = sin_v[17] ? 17'(-sin_v) : 17'(sin_v);
  assign cd_p  = cos_v[17] ? 17'(-cos_v) : 17'(cos_v);
  assign num_p = ({17'd0, as_p} << psct_pkg::FRAC_BITS) + 34'(cd_p >> 1);

  always_comb begin
    side_p.tan  = opp[2];
    side_p.neg  = sin_v[17] ^ cos_v[17];
    side_p.zero = (cos_v == 18'sd0);
    if (opp[2]) begin
      if (sin_v > 18'sd0) begin
        side_p.fix_val = psct_pkg::VAL_MAX;
      end else if (sin_v < 18'sd0) begin
        side_p.fix_val = psct_pkg::VAL_MIN;
      end else begin
        side_p.fix_val = '0;
      end
    end else if (opp[1]) begin
      side_p.fix_val = 32'(cos_v);
    end else begin
      side_p.fix_val = 32'(sin_v);
    end
  end

  // restoring divider, one quotient bit per stage
  logic                 dv_r   [0:DB];
  logic [33:0]          dn_r   [0:DB];
  logic [33:0]          dq_r   [0:DB];
  logic [15:0]          drem_r [0:DB];
  logic [16:0]          dcd_r  [0:DB];
  psct_pkg::psct_side_t dside_r[0:DB];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r[0] <= 1'b0;
    end else begin
      dv_r[0] <= sv_r[SL-1];
    end
  end

  always_ff @(posedge clk) begin
    dn_r[0]    <= num_p;
    dq_r[0]    <= '0;
    drem_r[0]  <= '0;
    dcd_r[0]   <= cd_p;
    dside_r[0] <= side_p;
  end

  for (genvar g = 0; g < DB; g++) begin : g_div
    logic [16:0] trial;
    logic        ge;
    assign trial = {drem_r[g], dn_r[g][33]};
    assign ge    = (trial >= dcd_r[g]);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[g+1] <= 1'b0;
      end else begin
        dv_r[g+1] <= dv_r[g];
      end
    end

    always_ff @(posedge clk) begin
      dn_r[g+1]    <= {dn_r[g][32:0], 1'b0};
      dq_r[g+1]    <= {dq_r[g][32:0], ge};
      drem_r[g+1]  <= 16'(ge ? trial - dcd_r[g] : trial);
      dcd_r[g+1]   <= dcd_r[g];
      dside_r[g+1] <= dside_r[g];
    end
  end

  // sign, clamp, select
  logic [33:0]          qf;
  psct_pkg::psct_side_t sf;
  psct_pkg::psct_out_t  res;
  assign qf = dq_r[DB];
  assign sf = dside_r[DB];

  always_comb begin
    res.value     = sf.fix_val;
    res.saturated = 1'b0;
    if (sf.tan) begin
      if (sf.zero) begin
        res.saturated = 1'b1;
      end else if (!sf.neg) begin
        if (qf > 34'h07FFFFFFF) begin
          res.value     = psct_pkg::VAL_MAX;
          res.saturated = 1'b1;
        end else begin
          res.value = $signed(qf[31:0]);
        end
      end else begin
        if (qf > 34'h080000000) begin
          res.value     = psct_pkg::VAL_MIN;
          res.saturated = 1'b1;
        end else begin
          res.value = $signed(32'(-qf));
        end
      end
    end
  end

  logic                out_valid_r;
  psct_pkg::psct_out_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= dv_r[DB];
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= res;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[hw/rtl/psct_checker.sv]
// ----------------------------------------------------------------------------
// psct_checker
// Port-level checks of the parabolic sine / cosine / tangent pipeline.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module psct_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input psct_pkg::psct_in_t  in_data,
  input logic                out_valid,
  input psct_pkg::psct_out_t out_data
);

  `PSCT_NEVER(a_no_busy, busy, "busy raised")
  `PSCT_ASSERT(a_req_to_res, (start && !busy) |-> ##46 out_valid, "request lost")
  `PSCT_ASSERT(a_res_from_req, out_valid |-> $past(start && !busy, 46), "extra result")
  `PSCT_ASSERT(a_sat_tan, (out_valid && out_data.saturated) |-> $past(in_data.op[2], 46), "saturated on sin/cos")

endmodule

bind parabolic_sine_cosine_tangent psct_checker u_psct_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_data  (out_data)
);
